>>> src/frame_check_and_sequence_tracker_defines.svh
// assertion macros shared by the frame check and sequence tracker modules
// expects aclk and aresetn in the scope where a macro is used
`ifndef FRAME_CHECK_AND_SEQUENCE_TRACKER_DEFINES_SVH
`define FRAME_CHECK_AND_SEQUENCE_TRACKER_DEFINES_SVH

// same-cycle implication
`define FCST_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fcst_pkg.sv
// types, constants and the crc byte update for the frame check and sequence tracker
// no dependencies
package fcst_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

    localparam logic [15:0] ROWS_RESET = 16'd200;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAGIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd2;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT  = 3'd0,
        VERDICT_DUP     = 3'd1,
        VERDICT_MAGIC   = 3'd2,
        VERDICT_VERSION = 3'd3,
        VERDICT_SIZE    = 3'd4,
        VERDICT_CRC     = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic [31:0] hdr_magic;
        logic [15:0] hdr_version;
        logic [15:0] hdr_rows;
        logic [31:0] hdr_seq;
        logic [31:0] rx_crc;
    } item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        publish;
        logic [30:0] missed_frames;
        logic        seq_restart;
    } result_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] rows;
    } cfg_t;

    // msb-first crc-32 update over one byte
    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h00_0000};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> src/fcst_crc_unit.sv
// running crc-32 register with a one-byte update per word
// depends on fcst_pkg and the assertion macro header
`include "frame_check_and_sequence_tracker_defines.svh"

module fcst_crc_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        is_last,
    input  logic [7:0]  data_byte,
    output logic [31:0] crc_calc
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;

    assign crc_calc = fcst_pkg::crc_byte(crc_reg, data_byte);

    always_comb begin
        crc_next = crc_reg;
        if (step) begin
            crc_next = is_last ? fcst_pkg::CRC_INIT : crc_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= fcst_pkg::CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    `FCST_ASSERT_NEXT(a_crc_restarts, step && is_last, crc_reg == fcst_pkg::CRC_INIT, "crc not reinitialized after frame")

endmodule

>>> src/fcst_seq_check.sv
// header and crc checks, then sequence tracking for frames that pass
// depends on fcst_pkg and the assertion macro header
`include "frame_check_and_sequence_tracker_defines.svh"

module fcst_seq_check (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_last,
    input  fcst_pkg::item_t   item,
    input  logic [31:0]       crc_calc,
    input  fcst_pkg::cfg_t    cfg,
    output fcst_pkg::result_t result
);

    logic [31:0] last_seq_reg;
    logic [31:0] last_seq_next;
    logic        have_seq_reg;
    logic        have_seq_next;
    logic [31:0] diff;

    assign diff = item.hdr_seq - last_seq_reg;

    always_comb begin
        result.verdict       = fcst_pkg::VERDICT_ACCEPT;
        result.missed_frames = '0;
        result.seq_restart   = 1'b0;
        last_seq_next        = last_seq_reg;
        have_seq_next        = have_seq_reg;
        if (item.hdr_magic != cfg.magic) begin
            result.verdict = fcst_pkg::VERDICT_MAGIC;
        end else if (item.hdr_version != cfg.version) begin
            result.verdict = fcst_pkg::VERDICT_VERSION;
        end else if (item.hdr_rows == 16'd0 || item.hdr_rows != cfg.rows) begin
            result.verdict = fcst_pkg::VERDICT_SIZE;
        end else if (crc_calc != item.rx_crc) begin
            result.verdict = fcst_pkg::VERDICT_CRC;
        end else if (!have_seq_reg) begin
            have_seq_next = 1'b1;
            last_seq_next = item.hdr_seq;
        end else if (diff == 32'd0) begin
            result.verdict = fcst_pkg::VERDICT_DUP;
        end else if (diff[31]) begin
            result.seq_restart = 1'b1;
            last_seq_next      = item.hdr_seq;
        end else begin
            result.missed_frames = diff[30:0] - 31'd1;
            last_seq_next        = item.hdr_seq;
        end
        result.publish = (result.verdict == fcst_pkg::VERDICT_ACCEPT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg <= '0;
            have_seq_reg <= 1'b0;
        end else if (step_last) begin
            last_seq_reg <= last_seq_next;
            have_seq_reg <= have_seq_next;
        end
    end

    `FCST_ASSERT_IMPL(a_gap_not_restart, step_last && result.seq_restart, result.missed_frames == 31'd0 && result.publish, "restart with missed count or unpublished")
    `FCST_ASSERT_NEXT(a_fail_keeps_seq, step_last && result.verdict != fcst_pkg::VERDICT_ACCEPT, $stable(last_seq_reg) && $stable(have_seq_reg), "rejected frame changed sequence state")

endmodule

>>> src/frame_check_and_sequence_tracker.sv
// top level: stream ports, configuration registers, input and result registers
// depends on fcst_pkg, fcst_crc_unit, fcst_seq_check and the assertion macro header
//
// usage
//   s_ channel: one word per covered frame byte; s_tlast marks the last byte, and the
//   header fields and received crc in s_tdata are read only on that word.
//   m_ channel: one word per frame, issued for the last byte only, carrying the
//   verdict, the publish flag, the missed frame count and the restart flag.
//   cfg_wr_en/cfg_index/cfg_data write expected magic (0), version (1), rows (2);
//   write only while no frame is in flight.
//   throughput: one word per cycle unless a last byte waits for the result register,
//   set by the combinational crc byte update and checks that sit between the input
//   register and the result register; a last byte passes both to reach m_tvalid.
//   when m_tready is low the result is held; non-last bytes keep flowing, and a
//   further last byte waits in the input register, dropping s_tready.
//   reset: crc back to all ones, no sequence seen, magic and version 0, rows 200,
//   both channels empty.
`include "frame_check_and_sequence_tracker_defines.svh"

module frame_check_and_sequence_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_byte, hdr_magic, hdr_version, hdr_rows, hdr_seq, rx_crc
    input  logic [fcst_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // verdict, publish, missed_frames, seq_restart, zero pad
    output logic [fcst_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [fcst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fcst_pkg::CFG_DATA_W-1:0]     cfg_data
);

    fcst_pkg::cfg_t    cfg_reg;
    fcst_pkg::cfg_t    cfg_next;
    fcst_pkg::item_t   s1_item_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    fcst_pkg::result_t m_result_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    fcst_pkg::item_t   in_item;
    fcst_pkg::result_t result;
    logic [31:0]       crc_calc;
    logic              out_free;
    logic              s1_advance;
    logic              step_last;
    logic              s_accept;

    assign in_item.data_byte   = s_tdata[7:0];
    assign in_item.is_last     = s_tlast;
    assign in_item.hdr_magic   = s_tdata[39:8];
    assign in_item.hdr_version = s_tdata[55:40];
    assign in_item.hdr_rows    = s_tdata[71:56];
    assign in_item.hdr_seq     = s_tdata[103:72];
    assign in_item.rx_crc      = s_tdata[135:104];

    assign out_free   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && (!s1_item_reg.is_last || out_free);
    assign step_last  = s1_advance && s1_item_reg.is_last;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fcst_pkg::CFG_IDX_MAGIC: begin
                    cfg_next.magic = cfg_data;
                end
                fcst_pkg::CFG_IDX_VERSION: begin
                    cfg_next.version = cfg_data[15:0];
                end
                fcst_pkg::CFG_IDX_ROWS: begin
                    cfg_next.rows = cfg_data[15:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (step_last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic   <= '0;
            cfg_reg.version <= '0;
            cfg_reg.rows    <= fcst_pkg::ROWS_RESET;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_item_reg <= in_item;
        end
        if (step_last) begin
            m_result_reg <= result;
        end
    end

    fcst_crc_unit u_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s1_advance),
        .is_last   (s1_item_reg.is_last),
        .data_byte (s1_item_reg.data_byte),
        .crc_calc  (crc_calc)
    );

    fcst_seq_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_last (step_last),
        .item      (s1_item_reg),
        .crc_calc  (crc_calc),
        .cfg       (cfg_reg),
        .result    (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, m_result_reg.seq_restart, m_result_reg.missed_frames,
                       m_result_reg.publish, m_result_reg.verdict};

    `FCST_ASSERT_NEXT(a_last_gives_result, step_last, m_valid_reg,
                      "last byte did not produce a result")

endmodule

>>> sim/frame_check_and_sequence_tracker_tb.sv
// testbench for frame_check_and_sequence_tracker: sends frames byte by byte and
// scores each frame verdict against a predictor kept alongside the stream
// depends on fcst_pkg and the frame_check_and_sequence_tracker rtl
module frame_check_and_sequence_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcst_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int RANDOM_WORDS  = 480;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 6;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [31:0] frame_crc = CRC_INIT;
    logic [31:0] prev_seq = '0;
    logic        seq_known = 1'b0;
    cfg_t        shadow_cfg = '{magic: 32'd0, version: 16'd0, rows: ROWS_RESET};
    result_t     pending_verdicts[$];

    // bookkeeping
    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int verdict_count[6];
    int gap_frames = 0;
    int restart_frames = 0;
    int hold_reqs = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    logic [31:0] stim_seq = 32'd0;

    frame_check_and_sequence_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // bit-serial crc-32, msb first
    function automatic logic [31:0] fold_crc_byte(logic [31:0] acc, logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[31] ^ b[k];
            r = {r[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("mismatch at result %0d: %s expected %0h got %0h",
                 results_seen, what, want, got);
    endtask

    // works out the verdict of one accepted word, if it closes a frame
    task automatic judge_frame_word(item_t w);
        logic [31:0] crc_now;
        logic [31:0] diff;
        verdict_t    v;
        result_t     r;
        crc_now = fold_crc_byte(frame_crc, w.data_byte);
        if (!w.is_last) begin
            frame_crc = crc_now;
            return;
        end
        frame_crc = CRC_INIT;
        v = VERDICT_ACCEPT;
        r = '0;
        if (w.hdr_magic != shadow_cfg.magic) begin
            v = VERDICT_MAGIC;
        end else if (w.hdr_version != shadow_cfg.version) begin
            v = VERDICT_VERSION;
        end else if (w.hdr_rows == 16'd0 || w.hdr_rows != shadow_cfg.rows) begin
            v = VERDICT_SIZE;
        end else if (crc_now != w.rx_crc) begin
            v = VERDICT_CRC;
        end else if (!seq_known) begin
            seq_known = 1'b1;
            prev_seq = w.hdr_seq;
        end else begin
            diff = w.hdr_seq - prev_seq;
            if (diff == 32'd0) begin
                v = VERDICT_DUP;
            end else if (diff[31]) begin
                r.seq_restart = 1'b1;
                prev_seq = w.hdr_seq;
                restart_frames++;
            end else begin
                r.missed_frames = diff[30:0] - 31'd1;
                prev_seq = w.hdr_seq;
                if (diff != 32'd1) gap_frames++;
            end
        end
        r.verdict = v;
        r.publish = (v == VERDICT_ACCEPT);
        verdict_count[v]++;
        pending_verdicts.push_back(r);
    endtask

    task automatic send_word(item_t w);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_tdata  <= {w.rx_crc, w.hdr_seq, w.hdr_rows, w.hdr_version, w.hdr_magic, w.data_byte};
        s_tlast  <= w.is_last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        judge_frame_word(w);
    endtask

    // fill < 0 gives random bytes
    task automatic send_frame(int len, int fill, logic [31:0] magic, logic [15:0] version,
                              logic [15:0] rows, logic [31:0] seq, bit crc_ok);
        item_t       w;
        logic [31:0] acc;
        acc = CRC_INIT;
        for (int i = 0; i < len; i++) begin
            w.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            acc = fold_crc_byte(acc, w.data_byte);
            w.is_last = (i == len - 1);
            if (w.is_last) begin
                w.hdr_magic   = magic;
                w.hdr_version = version;
                w.hdr_rows    = rows;
                w.hdr_seq     = seq;
                w.rx_crc      = crc_ok ? acc : acc ^ (32'($urandom) | 32'd1);
            end else begin
                w.hdr_magic   = $urandom;
                w.hdr_version = 16'($urandom);
                w.hdr_rows    = 16'($urandom);
                w.hdr_seq     = $urandom;
                w.rx_crc      = $urandom;
            end
            send_word(w);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_IDX_MAGIC:   shadow_cfg.magic = val;
            CFG_IDX_VERSION: shadow_cfg.version = val[15:0];
            CFG_IDX_ROWS:    shadow_cfg.rows = val[15:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] next_seq();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      stim_seq = stim_seq + 32'd1;
        else if (pick < 70) stim_seq = stim_seq + 32'($urandom_range(2, 20));
        else if (pick < 75) stim_seq = stim_seq + 32'($urandom_range(2, 32'h7FFF_FFFF));
        else if (pick < 82) stim_seq = stim_seq;
        else if (pick < 90) stim_seq = stim_seq - 32'($urandom_range(1, 50));
        else                stim_seq = $urandom;
        return stim_seq;
    endfunction

    task automatic send_random_frame(logic [31:0] magic, logic [15:0] version,
                                     logic [15:0] rows);
        int          len;
        int          pick;
        logic [31:0] m;
        logic [15:0] v;
        logic [15:0] r;
        bit          ok;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        m = magic;
        v = version;
        r = rows;
        ok = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 6)       m = magic ^ (32'($urandom) | 32'd1);
        else if (pick < 12) v = version ^ (16'($urandom) | 16'd1);
        else if (pick < 18) r = $urandom_range(0, 1) ? 16'd0 : rows ^ (16'($urandom) | 16'd1);
        else if (pick < 25) ok = 1'b0;
        send_frame(len, -1, m, v, r, next_seq(), ok);
    endtask

    task automatic test_reset_defaults();
        send_frame(2, 8'hFF, 32'd0, 16'd0, ROWS_RESET, 32'hFFFF_FFFF, 1'b1);
        send_frame(1, -1, 32'd0, 16'd0, 16'd0, 32'd7, 1'b1);
        wait_idle();
    endtask

    task automatic test_checks_and_sequence();
        write_reg(CFG_IDX_MAGIC, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_VERSION, {16'hA5A5, 16'hFFFF});
        write_reg(CFG_IDX_ROWS, {16'h5A5A, 16'hFFFF});
        send_frame(1, -1, 32'd0, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'd0, 16'hFFFF, 32'd0, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd0, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 32'd0, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0, 1'b0);
        // wrap from all ones to zero is next in order
        send_frame(1, 8'h00, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd4, 1'b1);
        // a failed frame must not move the sequence
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd100, 1'b0);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd5, 1'b1);
        wait_idle();
    endtask

    task automatic test_zero_rows_register();
        write_reg(CFG_IDX_ROWS, 32'd0);
        write_reg(CFG_IDX_UNUSED, $urandom);
        send_frame(1, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 32'd6, 1'b1);
        send_frame(2, -1, 32'hFFFF_FFFF, 16'hFFFF, 16'd5, 32'd6, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] rows;
        int          start;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    magic = $urandom;
                    version = 16'($urandom);
                    rows = 16'd1;
                end
                1: begin
                    magic = 32'd0;
                    version = 16'd0;
                    rows = 16'hFFFF;
                end
                default: begin
                    magic = $urandom;
                    version = 16'($urandom);
                    rows = 16'($urandom_range(1, 65535));
                end
            endcase
            write_reg(CFG_IDX_MAGIC, magic);
            write_reg(CFG_IDX_VERSION, {16'($urandom), version});
            write_reg(CFG_IDX_ROWS, {16'($urandom), rows});
            start = words_sent;
            while (words_sent - start < RANDOM_WORDS / 3) send_random_frame(magic, version, rows);
            wait_idle();
        end
    endtask

    task automatic test_output_backpressure();
        hold_reqs <= hold_reqs + 1;
        gaps_on = 1'b0;
        for (int i = 0; i < 24; i++) begin
            send_frame($urandom_range(1, 2), -1, shadow_cfg.magic, shadow_cfg.version,
                       shadow_cfg.rows, next_seq(), $urandom_range(0, 4) != 0);
        end
        gaps_on = 1'b1;
        wait_idle();
    endtask

    // receiver: ready patterns picked at random, plus a long hold on request
    initial begin : result_sink
        int mode;
        int mode_left;
        int served;
        mode = 0;
        mode_left = 0;
        served = 0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != served) begin
                served = hold_reqs;
                m_tready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++) @(posedge aclk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 64);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("word with no frame pending", 32'd0, m_tdata[31:0]);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[2:0] != want.verdict)
                    report_mismatch("verdict", want.verdict, m_tdata[2:0]);
                if (m_tdata[3] != want.publish)
                    report_mismatch("publish", want.publish, m_tdata[3]);
                if (m_tdata[34:4] != want.missed_frames)
                    report_mismatch("missed_frames", want.missed_frames, m_tdata[34:4]);
                if (m_tdata[35] != want.seq_restart)
                    report_mismatch("seq_restart", want.seq_restart, m_tdata[35]);
            end
        end
    end

    initial begin : watchdog
        #400_000;
        $display("timeout with %0d frames still pending", pending_verdicts.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_checks_and_sequence();
        test_zero_rows_register();
        test_random_traffic();
        test_output_backpressure();
        wait_idle();
        if (pending_verdicts.size() != 0)
            report_mismatch("frames left without a result", 32'd0, pending_verdicts.size());
        $display("sent %0d words, checked %0d frame results (accept %0d, dup %0d)",
                 words_sent, results_seen, verdict_count[VERDICT_ACCEPT],
                 verdict_count[VERDICT_DUP]);
        $display("bad magic %0d, version %0d, size %0d, crc %0d; gaps %0d, restarts %0d",
                 verdict_count[VERDICT_MAGIC], verdict_count[VERDICT_VERSION],
                 verdict_count[VERDICT_SIZE], verdict_count[VERDICT_CRC],
                 gap_frames, restart_frames);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/fcst_pkg.sv
src/fcst_crc_unit.sv
src/fcst_seq_check.sv
src/frame_check_and_sequence_tracker.sv
sim/frame_check_and_sequence_tracker_tb.sv
